// ----- hw/rtl/mean_deviation_ratio_top_defines.svh -----
// assertion macros shared by the mean deviation ratio checker
`ifndef MEAN_DEVIATION_RATIO_TOP_DEFINES_SVH
`define MEAN_DEVIATION_RATIO_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define MDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mdr_pkg.sv -----
// shared types and fixed constants of the mean deviation ratio block
`default_nettype none
package mdr_pkg;

  localparam int RATIO_W   = 24;
  localparam int FRAC_BITS = 16;
  // quotient keeps two bits above the ratio: rounding bit and overflow headroom
  localparam int Q_W       = RATIO_W + 2;

  localparam logic [Q_W-1:0] RATIO_POS_MAX = Q_W'(8388607);
  localparam logic [Q_W-1:0] RATIO_NEG_MAG = Q_W'(8388608);

  typedef struct packed {
    logic clear;
    logic rd_en;
  } acc_ctrl_t;

  typedef struct packed {
    logic           done;
    logic           ovf;
    logic [Q_W-1:0] q;
  } div_res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mdr_store.sv -----
// sample memory: one write port, one registered read port
`default_nettype none
module mdr_store #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024,
  parameter int IDX_W  = 10
) (
  input  wire logic              clk,
  input  wire logic              wr_en_i,
  input  wire logic [IDX_W-1:0]  wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [IDX_W-1:0]  rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/mdr_accum.sv -----
// deviation pipeline: N*x, minus S, absolute value into the accumulator
`default_nettype none
module mdr_accum
  import mdr_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 11
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire acc_ctrl_t                              ctrl_i,
  input  wire logic        [CNT_W-1:0]                n_i,
  input  wire logic signed [SAMPLE_BITS+CNT_W-1:0]    s_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          rdata_i,
  output logic             [SAMPLE_BITS+2*CNT_W+1:0]  acc_o,
  output logic                                        busy_o
);

  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int PROD_W = SUM_W + 1;
  localparam int DIFF_W = SUM_W + 2;
  localparam int ACC_W  = DIFF_W + CNT_W;

  logic                     v1_r, v2_r, v3_r;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  logic signed [DIFF_W-1:0] diff_nxt, diff_r;
  logic        [ACC_W-1:0]  diff_ext;
  logic        [ACC_W-1:0]  acc_nxt, acc_r;

  assign prod_nxt = $signed({1'b0, n_i}) * rdata_i;
  assign diff_nxt = DIFF_W'(prod_r) - DIFF_W'(s_i);
  assign diff_ext = ACC_W'(diff_r);
  // subtracting a negative difference adds its magnitude
  assign acc_nxt  = diff_r[DIFF_W-1] ? acc_r - diff_ext : acc_r + diff_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctrl_i.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    diff_r <= diff_nxt;
    if (ctrl_i.clear) begin
      acc_r <= '0;
    end else if (v3_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_o  = acc_r;
  assign busy_o = v1_r | v2_r | v3_r;

endmodule
`default_nettype wire

// ----- hw/rtl/mdr_div.sv -----
// restoring divider, one quotient bit per cycle, quotient overflow is sticky
`default_nettype none
module mdr_div
  import mdr_pkg::*;
#(
  parameter int ACC_W = 40,
  parameter int DEN_W = 38
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start_i,
  input  wire logic [ACC_W-1:0] dvd_i,
  input  wire logic [DEN_W-1:0] den_i,
  output div_res_t              res_o
);

  localparam int DVD_W  = ACC_W + FRAC_BITS + 1;
  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r, done_r, ovf_r;
  logic [STEP_W-1:0] step_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [DEN_W-1:0]  den_r, rem_r, rem_nxt;
  logic [Q_W-1:0]    q_r;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              q_bit;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign q_bit   = rem_sh >= {1'b0, den_r};
  assign rem_nxt = q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && step_r == STEP_W'(1)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      // dividend carries the fraction bits and the rounding bit below D
      dvd_r  <= {dvd_i, {(FRAC_BITS + 1){1'b0}}};
      den_r  <= den_i;
      rem_r  <= '0;
      q_r    <= '0;
      ovf_r  <= 1'b0;
      step_r <= STEP_W'(DVD_W);
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      q_r    <= {q_r[Q_W-2:0], q_bit};
      ovf_r  <= ovf_r | q_r[Q_W-1];
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign res_o.done = done_r;
  assign res_o.ovf  = ovf_r;
  assign res_o.q    = q_r;

endmodule
`default_nettype wire

// ----- hw/rtl/mean_deviation_ratio_top.sv -----
// mean absolute deviation over mean of a sample block, signed Q8.16 result
// samples load at one per cycle while in_stall is low; the marked last sample closes the block
// after the last sample, a read pass over the sample memory and the bit-serial divider
//   give the result; a block whose sum is zero skips both
// the input stalls until the result is loaded; the result register frees the input
// synchronous active-low reset empties the block; the sample memory is not cleared
`default_nettype none
module mean_deviation_ratio_top
  import mdr_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          in_last_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [RATIO_W-1:0]          out_ratio,
  output logic                               out_zero_mean,
  output logic                               out_saturated
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int ACC_W = SUM_W + 2 + CNT_W;
  localparam int DEN_W = CNT_W + SUM_W;

  typedef enum logic [4:0] {
    ST_LOAD  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_PASS  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]         rd_idx_r;
  logic                     neg_r, zero_r;
  logic [SUM_W-1:0]         abs_s_r;
  logic [DEN_W-1:0]         den_r;
  logic                     in_xfer, store_ok, pass_end, div_start, out_load;
  acc_ctrl_t                acc_ctrl;
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic [ACC_W-1:0]         acc;
  logic                     acc_busy;
  div_res_t                 div_res;
  logic [Q_W:0]             q_inc;
  logic [Q_W-1:0]           mag, limit, mag_c;
  logic                     sat;
  logic [RATIO_W-1:0]       ratio_nxt;
  logic                     out_valid_r, out_zero_r, out_sat_r;
  logic [RATIO_W-1:0]       out_ratio_r;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_xfer   = in_valid && !in_stall;
  assign store_ok  = count_r < CNT_W'(MAX_SAMPLES);
  assign pass_end  = (state_r == ST_PASS) && (rd_idx_r == count_r) && !acc_busy;
  assign div_start = pass_end;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign acc_ctrl.clear = (state_r == ST_SETUP);
  assign acc_ctrl.rd_en = (state_r == ST_PASS) && (rd_idx_r != count_r);

  mdr_store #(
    .DATA_W (SAMPLE_BITS),
    .DEPTH  (MAX_SAMPLES),
    .IDX_W  (IDX_W)
  ) u_store (
    .clk       (clk),
    .wr_en_i   (in_xfer && store_ok),
    .wr_addr_i (count_r[IDX_W-1:0]),
    .wr_data_i (in_sample),
    .rd_en_i   (acc_ctrl.rd_en),
    .rd_addr_i (rd_idx_r[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  mdr_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl_i  (acc_ctrl),
    .n_i     (count_r),
    .s_i     (sum_r),
    .rdata_i ($signed(rd_data)),
    .acc_o   (acc),
    .busy_o  (acc_busy)
  );

  mdr_div #(
    .ACC_W (ACC_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .dvd_i   (acc),
    .den_i   (den_r),
    .res_o   (div_res)
  );

  // round half up on the magnitude, then clip to the limit of the sign
  assign q_inc     = {1'b0, div_res.q} + (Q_W + 1)'(1);
  assign mag       = q_inc[Q_W:1];
  assign limit     = neg_r ? RATIO_NEG_MAG : RATIO_POS_MAX;
  assign sat       = div_res.ovf || (mag > limit);
  assign mag_c     = sat ? limit : mag;
  assign ratio_nxt = neg_r ? RATIO_W'(-mag_c[RATIO_W-1:0]) : mag_c[RATIO_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_last_sample) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = (sum_r == '0) ? ST_DONE : ST_PASS;
      end
      ST_PASS: begin
        if (pass_end) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        count_r <= '0;
        sum_r   <= '0;
      end else if (in_xfer && store_ok) begin
        count_r <= count_r + CNT_W'(1);
        sum_r   <= sum_r + SUM_W'(in_sample);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SETUP) begin
      zero_r   <= (sum_r == '0);
      neg_r    <= sum_r[SUM_W-1];
      abs_s_r  <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
      rd_idx_r <= '0;
    end else if (acc_ctrl.rd_en) begin
      rd_idx_r <= rd_idx_r + CNT_W'(1);
    end
    if (state_r == ST_PASS) begin
      den_r <= DEN_W'(count_r) * DEN_W'(abs_s_r);
    end
    if (out_load) begin
      out_zero_r  <= zero_r;
      out_sat_r   <= zero_r ? 1'b0 : sat;
      out_ratio_r <= zero_r ? '0 : ratio_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ratio     = $signed(out_ratio_r);
  assign out_zero_mean = out_zero_r;
  assign out_saturated = out_sat_r;

endmodule
`default_nettype wire

// ----- hw/rtl/mdr_checker.sv -----
// port-level checks of the mean deviation ratio block, bound to the top level
`default_nettype none
`include "mean_deviation_ratio_top_defines.svh"
module mdr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_last_sample,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_ratio,
  input wire logic        out_zero_mean,
  input wire logic        out_saturated
);

  `MDR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `MDR_ASSERT_NOW(a_zero_clean, out_valid && out_zero_mean, (out_ratio == 24'h000000) && !out_saturated, "zero mean with nonzero ratio")
  `MDR_ASSERT_NOW(a_sat_limit, out_valid && out_saturated, (out_ratio == 24'h7fffff) || (out_ratio == 24'h800000), "saturated ratio off the limits")
  `MDR_ASSERT_NEXT(a_last_busy, in_valid && !in_stall && in_last_sample, in_stall, "input open right after the last sample")

endmodule

bind mean_deviation_ratio_top mdr_checker u_mdr_checker (.*);
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the mean deviation ratio block with a built-in ratio predictor
module tb_top;
  import mdr_pkg::*;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_SAMPLES  = 1024;
  localparam int SMAX         = 32767;
  localparam int SMIN         = -32768;
  localparam int HOLD_CYCLES  = 600;
  localparam int TAIL_CYCLES  = 200;
  localparam int RUN_LIMIT_NS = 20_000_000;
  localparam int SHOW_LIMIT   = 10;

  typedef struct {
    logic signed [RATIO_W-1:0] ratio;
    logic                      zero_mean;
    logic                      saturated;
  } ratio_result_t;

  typedef enum {
    MIX_FULL,
    MIX_SMALL,
    MIX_POS_BIAS,
    MIX_NEG_BIAS,
    MIX_EXTREME,
    MIX_ZERO_SUM
  } sample_mix_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          in_last_sample = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [RATIO_W-1:0]     out_ratio;
  logic                          out_zero_mean;
  logic                          out_saturated;

  // predictor copy of the block being collected
  logic signed [SAMPLE_BITS-1:0] blk_samples [MAX_SAMPLES];
  int                            blk_count;
  longint                        blk_sum;
  ratio_result_t                 pending_ratios [$];

  int mismatch_count;
  int results_checked;
  int zero_mean_seen;
  int saturated_seen;
  int samples_sent;
  bit idle_en = 1'b1;
  int hold_req;
  int hold_left;
  int stall_left;

  mean_deviation_ratio_top #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_last_sample(in_last_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ratio     (out_ratio),
    .out_zero_mean (out_zero_mean),
    .out_saturated (out_saturated)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("TB_ERROR");
    $finish;
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic ratio_result_t compute_ratio();
    ratio_result_t res;
    longint        n, s, den, dev_sum, d, mag, limit;
    bit            neg;
    res.ratio     = '0;
    res.zero_mean = 1'b0;
    res.saturated = 1'b0;
    if (blk_sum == 0) begin
      res.zero_mean = 1'b1;
      return res;
    end
    n   = blk_count;
    s   = blk_sum;
    neg = s < 0;
    den = n * (neg ? -s : s);
    dev_sum = 0;
    for (int i = 0; i < blk_count; i++) begin
      d = n * longint'(blk_samples[i]) - s;
      dev_sum += (d < 0) ? -d : d;
    end
    // one extra fraction bit, then round half away from zero on the magnitude
    mag   = ((dev_sum <<< 17) / den + 1) >>> 1;
    limit = neg ? 64'sd8388608 : 64'sd8388607;
    if (mag > limit) begin
      mag = limit;
      res.saturated = 1'b1;
    end
    res.ratio = RATIO_W'(neg ? -mag : mag);
    return res;
  endfunction

  function automatic int draw_sample(sample_mix_t mix);
    case (mix)
      MIX_SMALL:    return int'($urandom_range(0, 40)) - 20;
      MIX_POS_BIAS: return 1000 + int'($urandom_range(0, 400));
      MIX_NEG_BIAS: return -int'($urandom_range(1, 32768));
      MIX_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return SMAX;
          1:       return SMIN;
          2:       return 1;
          default: return -1;
        endcase
      end
      MIX_ZERO_SUM: return int'($urandom_range(0, 200)) - 100;
      default:      return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic send_sample(input int value, input bit last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= SAMPLE_BITS'(value);
    in_last_sample <= last;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    // a full store drops the sample, marked or not
    if (blk_count < MAX_SAMPLES) begin
      blk_samples[blk_count] = SAMPLE_BITS'(value);
      blk_count++;
      blk_sum += value;
    end
    if (last) begin
      pending_ratios.push_back(compute_ratio());
      blk_count = 0;
      blk_sum   = 0;
    end
  endtask

  task automatic send_list(input int vals[$]);
    for (int i = 0; i < vals.size(); i++) begin
      send_sample(vals[i], i == vals.size() - 1);
    end
  endtask

  task automatic send_random_block(input int len);
    sample_mix_t mix;
    int          partial;
    int          v;
    mix     = sample_mix_t'($urandom_range(0, int'(MIX_ZERO_SUM)));
    partial = 0;
    for (int i = 0; i < len; i++) begin
      v = draw_sample(mix);
      // close on an exact zero sum when the cancelling value fits
      if (mix == MIX_ZERO_SUM && i == len - 1 && partial >= -SMAX && partial <= -SMIN) begin
        v = -partial;
      end
      send_sample(v, i == len - 1);
      partial += v;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_ratios.size() != 0);
  endtask

  task automatic run_random(input int n_samples);
    int start;
    int r;
    int len;
    start = samples_sent;
    while (samples_sent - start < n_samples) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 92) len = $urandom_range(9, 40);
      else if (r < 99) len = $urandom_range(41, 150);
      else len = $urandom_range(200, 400);
      send_random_block(len);
    end
    wait_drained();
  endtask

  task automatic test_directed();
    int blk [$];
    blk = '{SMAX};            send_list(blk);
    blk = '{SMIN};            send_list(blk);
    blk = '{0};               send_list(blk);
    blk = '{5, -5};           send_list(blk);
    blk = '{SMAX, -32766};    send_list(blk);
    blk = '{-32767, 32766};   send_list(blk);
    // ratio of exactly 128: clipped when positive, just fits when negative
    blk = '{129, -127};       send_list(blk);
    blk = '{127, -129};       send_list(blk);
    blk = '{1, 3};            send_list(blk);
    blk = '{1, 2};            send_list(blk);
    blk = '{-1, -1, -2};      send_list(blk);
    blk = '{SMAX, SMAX, SMAX, SMIN}; send_list(blk);
    wait_drained();
  endtask

  task automatic test_store_full();
    // the last two samples, the marked one among them, must be dropped
    for (int i = 0; i < MAX_SAMPLES + 2; i++) begin
      send_sample(draw_sample(MIX_FULL), i == MAX_SAMPLES + 1);
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_en  = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (30) send_random_block($urandom_range(1, 2));
    wait_drained();
    idle_en = 1'b1;
  endtask

  task automatic test_random_blocks();
    run_random(650);
  endtask

  task automatic test_streaming();
    idle_en = 1'b0;
    run_random(200);
    idle_en = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : check_result
    ratio_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_ratios.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT) begin
          $display("unexpected result: ratio %0d zero_mean %0b saturated %0b",
                   out_ratio, out_zero_mean, out_saturated);
        end
      end else begin
        want = pending_ratios.pop_front();
        zero_mean_seen += want.zero_mean;
        saturated_seen += want.saturated;
        if (out_ratio !== want.ratio || out_zero_mean !== want.zero_mean ||
            out_saturated !== want.saturated) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT) begin
            $display("result %0d mismatch: ratio exp %0d got %0d, zero_mean exp %0b got %0b, %s",
                     results_checked, want.ratio, out_ratio, want.zero_mean, out_zero_mean,
                     $sformatf("saturated exp %0b got %0b", want.saturated, out_saturated));
          end
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_backpressure();
    test_random_blocks();
    test_streaming();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d samples sent, %0d results checked (%0d zero mean, %0d saturated)",
             samples_sent, results_checked, zero_mean_seen, saturated_seen);
    $display("covered extremes, overfull store, long output hold-off and gapless streaming");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mdr_pkg.sv
hw/rtl/mdr_store.sv
hw/rtl/mdr_accum.sv
hw/rtl/mdr_div.sv
hw/rtl/mean_deviation_ratio_top.sv
hw/rtl/mdr_checker.sv
verif/tb_top.sv
